### src/tss_pkg.sv
// ----------------------------------------------------------------------------
// Taylor sine/cosine package
// Shared widths, defaults and register map for the Taylor series block.
// ----------------------------------------------------------------------------
`default_nettype none

package tss_pkg;

	localparam int ANGLE_W          = 16;
	localparam int RESULT_W         = 32;
	localparam int ORDER_W          = 4;
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 2;

	localparam int MAX_ORDER_DEF    = 10;
	localparam int ANGLE_FRAC_DEF   = 12;
	localparam int RESULT_FRAC_DEF  = 16;

	localparam int WORK_FRAC        = 24;
	localparam int TERM_INT_BITS    = 20;
	localparam int DIV_BITS_PER_CYC = 8;

	localparam logic [ORDER_W-1:0] SERIES_ORDER_RESET = 4'd5;

	localparam logic [APB_ADDR_W-1:0] ADDR_SERIES_ORDER = '0;

endpackage

`default_nettype wire

### src/taylor_sine_cosine.sv
// ----------------------------------------------------------------------------
// Taylor series sine/cosine
// Sums the truncated Taylor series of sine or cosine for a fixed-point angle
// with one shared multiplier and a small-divisor digit divider.
// Sequence: an accepted start goes to ST_FIN when there is no series step, else each
// of the N steps runs ST_MUL, then ST_DIV until the digit divider has its quotient,
// then ST_ACC; ST_FIN registers the result and raises done. N is 2k for cosine, 2k+1
// for sine, k the clamped order, fewer after a term overflow. busy falls as done rises,
// and start is taken only while idle. The receiver cannot stall: done pulses for one cycle.
// Reset clears the sequencer and sets series_order to 5.
// ----------------------------------------------------------------------------
`default_nettype none

module taylor_sine_cosine #(
	parameter int MAX_ORDER        = tss_pkg::MAX_ORDER_DEF,
	parameter int ANGLE_FRAC_BITS  = tss_pkg::ANGLE_FRAC_DEF,
	parameter int RESULT_FRAC_BITS = tss_pkg::RESULT_FRAC_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output      logic                              busy,
	input  wire logic                              cmd,
	input  wire logic signed [tss_pkg::ANGLE_W-1:0] angle,
	output      logic                              done,
	output      logic signed [tss_pkg::RESULT_W-1:0] approx_value,
	output      logic                              saturated,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [tss_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [tss_pkg::APB_DATA_W-1:0]    pwdata,
	output      logic [tss_pkg::APB_DATA_W-1:0]    prdata,
	output      logic                              pready
);

	import tss_pkg::*;

	localparam int T_W    = WORK_FRAC + TERM_INT_BITS + 1;
	localparam int MAG_W  = ANGLE_W;
	localparam int P_W    = T_W + MAG_W;
	localparam int Q_W    = P_W - ANGLE_FRAC_BITS;
	localparam int NDIV   = (Q_W + DIV_BITS_PER_CYC - 1) / DIV_BITS_PER_CYC;
	localparam int QPAD   = NDIV * DIV_BITS_PER_CYC;
	localparam int DCNT_W = $clog2(NDIV);
	localparam int M_W    = $clog2(2 * MAX_ORDER + 2);
	localparam int ACC_W  = T_W + 6;
	localparam int SHIFT  = WORK_FRAC - RESULT_FRAC_BITS;

	localparam logic [T_W-1:0]   ONE_T  = T_W'(1) << WORK_FRAC;
	localparam logic [QPAD-1:0]  CAP    = QPAD'(1) << (WORK_FRAC + TERM_INT_BITS);
	localparam logic [ACC_W-1:0] HALF   = (ACC_W'(1) << SHIFT) >> 1;
	localparam logic [ACC_W-1:0] POS_LIM = ACC_W'(33'h0_7FFF_FFFF);
	localparam logic [ACC_W-1:0] NEG_LIM = ACC_W'(33'h0_8000_0000);
	localparam logic [ORDER_W-1:0] K_MAX = ORDER_W'(MAX_ORDER);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]               state_q;
	logic [ORDER_W-1:0]       series_order_q;
	logic                     cos_q;
	logic                     xneg_q;
	logic                     ovf_neg_q;
	logic                     ovf_q;
	logic [MAG_W-1:0]         mag_q;
	logic [M_W-1:0]           m_q;
	logic [M_W-1:0]           mmax_q;
	logic [T_W-1:0]           t_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [QPAD-1:0]          div_q;
	logic [M_W-1:0]           rem_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic                     done_q;
	logic [RESULT_W-1:0]      value_q;
	logic                     sat_q;

	logic                     accept;
	logic                     cfg_sel;
	logic                     cfg_wr;
	logic [ORDER_W-1:0]       k_eff;
	logic [MAG_W-1:0]         mag_in;
	logic [M_W-1:0]           mmax_in;
	logic [P_W-1:0]           prod;
	logic [QPAD-1:0]          q_round;
	logic [QPAD-1:0]          div_nxt;
	logic [M_W-1:0]           rem_nxt;
	logic                     term_hit;
	logic                     term_neg;
	logic                     acc_neg;
	logic [ACC_W-1:0]         acc_mag;
	logic [ACC_W-1:0]         acc_rnd;
	logic [ACC_W-1:0]         lim;
	logic                     fin_sat;
	logic [RESULT_W-1:0]      fin_value;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign pready  = 1'b1;
	assign cfg_sel = (paddr == ADDR_SERIES_ORDER);
	assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;
	assign prdata  = cfg_sel ? APB_DATA_W'(series_order_q) : '0;

	assign done         = done_q;
	assign approx_value = value_q;
	assign saturated    = sat_q;

	assign k_eff   = (series_order_q > K_MAX) ? K_MAX : series_order_q;
	assign mag_in  = angle[ANGLE_W-1] ? (MAG_W'(0) - MAG_W'(angle)) : MAG_W'(angle);
	assign mmax_in = (M_W'(k_eff) << 1) | M_W'(!cmd);

	assign prod    = P_W'(t_q) * P_W'(mag_q);
	assign q_round = QPAD'((prod + (P_W'(m_q) << (ANGLE_FRAC_BITS - 1))) >> ANGLE_FRAC_BITS);

	always_comb begin
		logic [QPAD-1:0] dv;
		logic [M_W:0]    r;
		logic [M_W-1:0]  rr;
		dv = div_q;
		rr = rem_q;
		for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
			r  = {rr, dv[QPAD-1]};
			dv = dv << 1;
			if (r >= {1'b0, m_q}) begin
				r     = r - {1'b0, m_q};
				dv[0] = 1'b1;
			end
			rr = r[M_W-1:0];
		end
		div_nxt = dv;
		rem_nxt = rr;
	end

	assign term_hit = (m_q[0] != cos_q);
	assign term_neg = (M_W > 1) ? (m_q[M_W > 1 ? 1 : 0] ^ (!cos_q && xneg_q))
		: (!cos_q && xneg_q);

	assign acc_neg = acc_q[ACC_W-1];
	assign acc_mag = acc_neg ? (ACC_W'(0) - ACC_W'(acc_q)) : ACC_W'(acc_q);
	assign acc_rnd = (acc_mag + HALF) >> SHIFT;
	assign lim     = acc_neg ? NEG_LIM : POS_LIM;

	always_comb begin
		logic [ACC_W-1:0] u;
		u = acc_rnd;
		if (ovf_q) begin
			fin_sat   = 1'b1;
			fin_value = ovf_neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			fin_sat = (u > lim);
			if (fin_sat) begin
				u = lim;
			end
			fin_value = acc_neg ? (RESULT_W'(0) - u[RESULT_W-1:0]) : u[RESULT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_order_q <= SERIES_ORDER_RESET;
		end else if (cfg_wr) begin
			series_order_q <= pwdata[ORDER_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			dcnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (mmax_in == '0) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					dcnt_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(NDIV - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (div_q > CAP || m_q == mmax_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cos_q     <= cmd;
					xneg_q    <= angle[ANGLE_W-1];
					ovf_neg_q <= k_eff[0] ^ (!cmd && angle[ANGLE_W-1]);
					ovf_q     <= 1'b0;
					mag_q     <= mag_in;
					mmax_q    <= mmax_in;
					m_q       <= M_W'(1);
					t_q       <= ONE_T;
					acc_q     <= cmd ? signed'(ACC_W'(ONE_T)) : '0;
				end
			end
			ST_MUL: begin
				div_q <= q_round;
				rem_q <= '0;
			end
			ST_DIV: begin
				div_q <= div_nxt;
				rem_q <= rem_nxt;
			end
			ST_ACC: begin
				if (div_q > CAP) begin
					ovf_q <= 1'b1;
				end else begin
					t_q <= div_q[T_W-1:0];
					m_q <= m_q + 1'b1;
					if (term_hit) begin
						if (term_neg) begin
							acc_q <= acc_q - signed'(ACC_W'(div_q[T_W-1:0]));
						end else begin
							acc_q <= acc_q + signed'(ACC_W'(div_q[T_W-1:0]));
						end
					end
				end
			end
			ST_FIN: begin
				value_q <= fin_value;
				sat_q   <= fin_sat;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
